// ===== hdl/pgn_tag_pair_parser_core_assert.svh =====
// Assertion macros for the checker file of the tag pair parser.
// PTP_ASSERT_RUN is not checked while reset is asserted; PTP_ASSERT_ANY is.
`ifndef PGN_TAG_PAIR_PARSER_CORE_ASSERT_SVH
`define PGN_TAG_PAIR_PARSER_CORE_ASSERT_SVH

`define PTP_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define PTP_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/ptp_pkg.sv =====
package ptp_pkg;

    // Halt status codes.
    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_STOP   = 3'd1;
    localparam logic [2:0] ST_SYNTAX = 3'd2;
    localparam logic [2:0] ST_EOF    = 3'd3;
    localparam logic [2:0] ST_LONG   = 3'd4;

    // Special bytes.
    localparam logic [7:0] CH_OPEN   = 8'h5B; // [
    localparam logic [7:0] CH_CLOSE  = 8'h5D; // ]
    localparam logic [7:0] CH_QUOTE  = 8'h22; // "
    localparam logic [7:0] CH_BSLASH = 8'h5C; // backslash
    localparam logic [7:0] CH_CTRL_TOP = 8'd31;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_item;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] out_char;
        logic       in_value;
        logic       name_done;
        logic       value_done;
        logic       tag_done;
        logic [2:0] status;
    } t_result;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_name(input logic [7:0] b);
        return is_alnum(b) || b == 8'h5F || b == 8'h2B || b == 8'h23 ||
               b == 8'h3D || b == 8'h3A || b == 8'h2D;
    endfunction

endpackage

// ===== hdl/ptp_in_stage.sv =====
module ptp_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ptp_pkg::t_item i_item,
    output logic          o_in_stall,
    input  logic          i_take,
    output logic          o_valid,
    output ptp_pkg::t_item o_item
);
    import ptp_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The held request leaves when the parser consumes it; a new one may
    // enter in the same cycle.
    assign o_in_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== hdl/ptp_fsm.sv =====
module ptp_fsm #(
    parameter int NAME_LIMIT  = 64,
    parameter int VALUE_LIMIT = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  ptp_pkg::t_item  i_item,
    output ptp_pkg::t_result o_result
);
    import ptp_pkg::*;

    localparam logic [3:0] PH_OPEN       = 4'd0;
    localparam logic [3:0] PH_NAME_FIRST = 4'd1;
    localparam logic [3:0] PH_NAME_REST  = 4'd2;
    localparam logic [3:0] PH_QUOTE      = 4'd3;
    localparam logic [3:0] PH_VALUE      = 4'd4;
    localparam logic [3:0] PH_CLOSE      = 4'd5;

    localparam logic [6:0] NameMax  = 7'(NAME_LIMIT);
    localparam logic [7:0] ValueMax = 8'(VALUE_LIMIT);

    logic [3:0] r_phase, n_phase;
    logic       r_esc, n_esc;
    logic [6:0] r_name_len, n_name_len;
    logic [7:0] r_val_len, n_val_len;
    logic [2:0] r_halt, n_halt;
    t_result    res;
    logic [7:0] b;

    assign b = i_item.in_byte;

    always_comb begin
        n_phase    = r_phase;
        n_esc      = r_esc;
        n_name_len = r_name_len;
        n_val_len  = r_val_len;
        n_halt     = r_halt;
        res        = '0;

        if (r_halt != ST_RUN) begin
            // Halted for good: nothing changes.
        end else if (i_item.end_of_input) begin
            n_halt = ST_EOF;
        end else begin
            unique case (r_phase)
                PH_OPEN: begin
                    if (!is_space(b)) begin
                        if (b == CH_OPEN) n_phase = PH_NAME_FIRST;
                        else              n_halt  = ST_STOP;
                    end
                end
                PH_NAME_FIRST: begin
                    if (!is_space(b)) begin
                        if (!is_alnum(b)) begin
                            n_halt = ST_SYNTAX;
                        end else if (NameMax == 7'd0) begin
                            n_halt = ST_LONG;
                        end else begin
                            n_name_len     = 7'd1;
                            res.char_valid = 1'b1;
                            res.out_char   = b[6:0];
                            n_phase        = PH_NAME_REST;
                        end
                    end
                end
                PH_NAME_REST: begin
                    if (is_name(b)) begin
                        if (r_name_len >= NameMax) begin
                            n_halt = ST_LONG;
                        end else begin
                            n_name_len     = r_name_len + 7'd1;
                            res.char_valid = 1'b1;
                            res.out_char   = b[6:0];
                        end
                    end else begin
                        // Whatever byte ends the name is dropped.
                        res.name_done = 1'b1;
                        n_phase       = PH_QUOTE;
                    end
                end
                PH_QUOTE: begin
                    if (!is_space(b)) begin
                        if (b == CH_QUOTE) begin
                            n_val_len = 8'd0;
                            n_esc     = 1'b0;
                            n_phase   = PH_VALUE;
                        end else begin
                            n_halt = ST_SYNTAX;
                        end
                    end
                end
                PH_VALUE: begin
                    if (r_esc) begin
                        if (b == CH_BSLASH || b == CH_QUOTE) begin
                            n_esc = 1'b0;
                            if (r_val_len >= ValueMax) begin
                                n_halt = ST_LONG;
                            end else begin
                                n_val_len      = r_val_len + 8'd1;
                                res.char_valid = 1'b1;
                                res.out_char   = b[6:0];
                                res.in_value   = 1'b1;
                            end
                        end else begin
                            n_halt = ST_SYNTAX;
                        end
                    end else if (b == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        res.value_done = 1'b1;
                        n_phase        = PH_CLOSE;
                    end else if (b > CH_CTRL_TOP && !b[7]) begin
                        if (r_val_len >= ValueMax) begin
                            n_halt = ST_LONG;
                        end else begin
                            n_val_len      = r_val_len + 8'd1;
                            res.char_valid = 1'b1;
                            res.out_char   = b[6:0];
                            res.in_value   = 1'b1;
                        end
                    end else begin
                        n_halt = ST_SYNTAX;
                    end
                end
                PH_CLOSE: begin
                    if (!is_space(b)) begin
                        if (b == CH_CLOSE) begin
                            res.tag_done = 1'b1;
                            n_name_len   = 7'd0;
                            n_val_len    = 8'd0;
                            n_esc        = 1'b0;
                            n_phase      = PH_OPEN;
                        end else begin
                            n_halt = ST_SYNTAX;
                        end
                    end
                end
                default: n_halt = ST_SYNTAX;
            endcase
        end

        // A halting step, and every step after it, shows only the status.
        if (n_halt != ST_RUN) begin
            res = '0;
        end
        res.status = n_halt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPEN;
            r_esc      <= 1'b0;
            r_name_len <= 7'd0;
            r_val_len  <= 8'd0;
            r_halt     <= ST_RUN;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_esc      <= n_esc;
            r_name_len <= n_name_len;
            r_val_len  <= n_val_len;
            r_halt     <= n_halt;
        end
    end

    assign o_result = res;
endmodule

// ===== hdl/ptp_out_stage.sv =====
module ptp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ptp_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ptp_pkg::t_result o_result
);
    import ptp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The register takes a new result whenever it is empty or being drained.
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;
endmodule

// ===== hdl/pgn_tag_pair_parser_core.sv =====
// Tag pair parser: takes one text byte per request and returns one result per
// request, either a decoded name or value character with its end flags, or
// status only. A request passes through an input register and a result
// register; its result is loaded into the result register once that register
// is empty or being drained, and is presented from there. One request is taken
// every cycle while the output is not stalled. The whole parse step (phase,
// escape flag, length counters, halt status) is computed combinationally and
// registered at once, which sets that rate. Once status turns nonzero the block
// stays halted until reset and every later result carries that status alone.
module pgn_tag_pair_parser_core #(
    parameter int NAME_LIMIT  = 64,
    parameter int VALUE_LIMIT = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_char_valid,
    output logic [6:0] o_out_char,
    output logic       o_in_value,
    output logic       o_name_done,
    output logic       o_value_done,
    output logic       o_tag_done,
    output logic [2:0] o_status
);
    import ptp_pkg::*;

    t_item   in_item, held_item;
    t_result step_res, out_res;
    logic    held_valid, out_ready;

    assign in_item.in_byte      = i_in_byte;
    assign in_item.end_of_input = i_end_of_input;

    ptp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (in_item),
        .o_in_stall (o_in_stall),
        .i_take     (out_ready),
        .o_valid    (held_valid),
        .o_item     (held_item)
    );

    ptp_fsm #(
        .NAME_LIMIT  (NAME_LIMIT),
        .VALUE_LIMIT (VALUE_LIMIT)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (held_valid && out_ready),
        .i_item   (held_item),
        .o_result (step_res)
    );

    ptp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_result    (step_res),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_res)
    );

    assign o_char_valid = out_res.char_valid;
    assign o_out_char   = out_res.out_char;
    assign o_in_value   = out_res.in_value;
    assign o_name_done  = out_res.name_done;
    assign o_value_done = out_res.value_done;
    assign o_tag_done   = out_res.tag_done;
    assign o_status     = out_res.status;
endmodule

// ===== hdl/ptp_checker.sv =====
`include "pgn_tag_pair_parser_core_assert.svh"

module ptp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_char_valid,
    input logic [6:0] o_out_char,
    input logic       o_in_value,
    input logic       o_name_done,
    input logic       o_value_done,
    input logic       o_tag_done,
    input logic [2:0] o_status
);
    import ptp_pkg::*;

    // A halted result never carries a character or a done flag.
    `PTP_ASSERT_RUN(a_halt_quiet, o_out_valid && o_status != ST_RUN |-> !o_char_valid && !o_name_done && !o_value_done && !o_tag_done, "flags set in a halted result")

    // At most one kind of event per result.
    `PTP_ASSERT_RUN(a_one_event, o_out_valid |-> $onehot0({o_char_valid, o_name_done, o_value_done, o_tag_done}), "more than one event in a result")

    // Without a character the character fields read zero.
    `PTP_ASSERT_RUN(a_char_zero, o_out_valid && !o_char_valid |-> o_out_char == 7'd0 && !o_in_value, "character fields set without a character")

    // A stalled result holds.
    `PTP_ASSERT_RUN(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable({o_char_valid, o_out_char, o_in_value, o_name_done, o_value_done, o_tag_done, o_status}), "stalled result changed")

    // No result right after reset.
    `PTP_ASSERT_ANY(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")
endmodule

bind pgn_tag_pair_parser_core ptp_checker u_ptp_checker (.*);

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptp_pkg::*;

    localparam int NAME_MAX   = 64;
    localparam int VALUE_MAX  = 255;
    localparam int CYCLE_CAP  = 200000;
    localparam int RANDOM_BYTES = 430;

    // Where the parser stands between bytes.
    typedef enum logic [2:0] {
        SEEK_OPEN, NAME_HEAD, NAME_BODY, SEEK_QUOTE, IN_VALUE, SEEK_CLOSE
    } parse_phase_e;

    // How the byte stream is brought to its halt.
    typedef enum int {
        END_STOP, END_NAME_START, END_NO_QUOTE, END_BAD_ESCAPE, END_BAD_VALUE_BYTE,
        END_NO_CLOSE, END_EOF, END_NAME_LONG, END_VALUE_LONG
    } halt_path_e;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
        int         gap;
        bit         drain_first;
    } text_item_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_byte = '0;
    logic       i_end_of_input = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_char_valid;
    logic [6:0] o_out_char;
    logic       o_in_value;
    logic       o_name_done;
    logic       o_value_done;
    logic       o_tag_done;
    logic [2:0] o_status;

    text_item_t text_bytes[$];
    t_result    parse_results_due[$];
    int         pushed_count = 0;
    bit         hold_next = 1'b0;
    int         idle_count = 0;
    logic       next_valid;
    int         stall_left = 0;
    int         results_seen = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    // Predictor state, reset values.
    parse_phase_e phase = SEEK_OPEN;
    bit           esc_pending = 1'b0;
    int           name_len_q = 0;
    int           value_len_q = 0;
    logic [2:0]   halt_code = ST_RUN;

    pgn_tag_pair_parser_core #(
        .NAME_LIMIT (NAME_MAX),
        .VALUE_LIMIT(VALUE_MAX)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_input(i_end_of_input),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_char_valid  (o_char_valid),
        .o_out_char    (o_out_char),
        .o_in_value    (o_in_value),
        .o_name_done   (o_name_done),
        .o_value_done  (o_value_done),
        .o_tag_done    (o_tag_done),
        .o_status      (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit byte_is_blank(input logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic bit byte_is_alnum(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit byte_is_name_char(input logic [7:0] b);
        return byte_is_alnum(b) || b == "_" || b == "+" || b == "#" || b == "=" ||
               b == ":" || b == "-";
    endfunction

    task automatic append_value(input logic [7:0] b, inout t_result r);
        if (value_len_q + 1 > VALUE_MAX) begin
            halt_code = ST_LONG;
        end else begin
            value_len_q++;
            r.char_valid = 1'b1;
            r.out_char = b[6:0];
            r.in_value = 1'b1;
        end
    endtask

    // Advances the parser state by one byte and queues the result it causes.
    task automatic parse_byte(input logic [7:0] b, input logic eoi);
        t_result r;
        r = '0;
        if (halt_code == ST_RUN && eoi) begin
            halt_code = ST_EOF;
        end else if (halt_code == ST_RUN) begin
            case (phase)
                SEEK_OPEN: begin
                    if (!byte_is_blank(b)) begin
                        if (b == CH_OPEN) phase = NAME_HEAD;
                        else halt_code = ST_STOP;
                    end
                end
                NAME_HEAD: begin
                    if (!byte_is_blank(b)) begin
                        if (!byte_is_alnum(b)) begin
                            halt_code = ST_SYNTAX;
                        end else begin
                            name_len_q = 1;
                            r.char_valid = 1'b1;
                            r.out_char = b[6:0];
                            phase = NAME_BODY;
                        end
                    end
                end
                NAME_BODY: begin
                    if (byte_is_name_char(b)) begin
                        if (name_len_q + 1 > NAME_MAX) begin
                            halt_code = ST_LONG;
                        end else begin
                            name_len_q++;
                            r.char_valid = 1'b1;
                            r.out_char = b[6:0];
                        end
                    end else begin
                        // Any other byte closes the name and is dropped.
                        r.name_done = 1'b1;
                        phase = SEEK_QUOTE;
                    end
                end
                SEEK_QUOTE: begin
                    if (!byte_is_blank(b)) begin
                        if (b == CH_QUOTE) begin
                            value_len_q = 0;
                            esc_pending = 1'b0;
                            phase = IN_VALUE;
                        end else begin
                            halt_code = ST_SYNTAX;
                        end
                    end
                end
                IN_VALUE: begin
                    if (esc_pending) begin
                        if (b == CH_BSLASH || b == CH_QUOTE) begin
                            esc_pending = 1'b0;
                            append_value(b, r);
                        end else begin
                            halt_code = ST_SYNTAX;
                        end
                    end else if (b == CH_BSLASH) begin
                        esc_pending = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        r.value_done = 1'b1;
                        phase = SEEK_CLOSE;
                    end else if (b > CH_CTRL_TOP && b < 8'd128) begin
                        append_value(b, r);
                    end else begin
                        halt_code = ST_SYNTAX;
                    end
                end
                SEEK_CLOSE: begin
                    if (!byte_is_blank(b)) begin
                        if (b == CH_CLOSE) begin
                            r.tag_done = 1'b1;
                            name_len_q = 0;
                            value_len_q = 0;
                            esc_pending = 1'b0;
                            phase = SEEK_OPEN;
                        end else begin
                            halt_code = ST_SYNTAX;
                        end
                    end
                end
                default: halt_code = ST_SYNTAX;
            endcase
        end
        if (halt_code != ST_RUN) r = '0;
        r.status = halt_code;
        parse_results_due.push_back(r);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eoi = 1'b0);
        text_item_t it;
        it.data = b;
        it.eoi = eoi;
        it.drain_first = hold_next;
        // Every third stretch of bytes goes out back to back.
        it.gap = ((pushed_count / 60) % 3 == 1) ? 0 : $urandom_range(9);
        hold_next = 1'b0;
        text_bytes.push_back(it);
        pushed_count++;
    endtask

    task automatic push_blanks();
        int n;
        n = $urandom_range(2);
        repeat (n) push_byte($urandom_range(1) ? 8'd32 : 8'($urandom_range(13, 9)));
    endtask

    function automatic logic [7:0] draw_name_byte(input bit lead);
        logic [7:0] b;
        do b = 8'($urandom_range(126, 33));
        while (lead ? !byte_is_alnum(b) : !byte_is_name_char(b));
        return b;
    endfunction

    task automatic push_head(input int name_len);
        push_blanks();
        push_byte(CH_OPEN);
        push_blanks();
        push_byte(draw_name_byte(1'b1));
        repeat (name_len - 1) push_byte(draw_name_byte(1'b0));
    endtask

    task automatic push_term();
        logic [7:0] b;
        case ($urandom_range(3))
            0: b = CH_QUOTE;
            1: b = 8'd32;
            default: begin
                do b = 8'($urandom_range(255)); while (byte_is_name_char(b));
            end
        endcase
        push_byte(b);
    endtask

    task automatic push_value_char();
        logic [7:0] b;
        if ($urandom_range(7) == 0) begin
            push_byte(CH_BSLASH);
            push_byte($urandom_range(1) ? CH_BSLASH : CH_QUOTE);
        end else begin
            do b = 8'($urandom_range(127, 32)); while (b == CH_QUOTE || b == CH_BSLASH);
            push_byte(b);
        end
    endtask

    // Terminator, opening quote and the value characters.
    task automatic push_body(input int value_len);
        push_term();
        push_blanks();
        push_byte(CH_QUOTE);
        repeat (value_len) push_value_char();
    endtask

    task automatic push_tail();
        push_byte(CH_QUOTE);
        push_blanks();
        push_byte(CH_CLOSE);
    endtask

    // Request side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_count = 0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_in_byte, i_end_of_input);
                next_valid = 1'b0;
            end
            if (!next_valid && text_bytes.size() != 0) begin
                if (text_bytes[0].drain_first && parse_results_due.size() != 0) begin
                    idle_count = 0;
                end else if (idle_count < text_bytes[0].gap) begin
                    idle_count++;
                end else begin
                    i_in_byte <= text_bytes[0].data;
                    i_end_of_input <= text_bytes[0].eoi;
                    next_valid = 1'b1;
                    idle_count = 0;
                    text_bytes.delete(0);
                end
            end
            i_in_valid <= next_valid;
        end
    end

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Result side.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (parse_results_due.size() == 0) begin
                    $error("result arrived with nothing expected");
                    mismatch_count++;
                end else begin
                    want = parse_results_due.pop_front();
                    compare_field("char_valid", want.char_valid, o_char_valid);
                    compare_field("out_char", want.out_char, o_out_char);
                    compare_field("in_value", want.in_value, o_in_value);
                    compare_field("name_done", want.name_done, o_name_done);
                    compare_field("value_done", want.value_done, o_value_done);
                    compare_field("tag_done", want.tag_done, o_tag_done);
                    compare_field("status", want.status, o_status);
                end
                results_seen++;
                stall_left = ((results_seen / 64) % 3 == 1) ? 0 : $urandom_range(9);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left != 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        halt_path_e   path;
        parse_phase_e cut;
        logic [7:0]   b;
        int           pairs;

        // Every blank, every name punctuation mark, both escapes, the highest value
        // byte 127 and a quote used as the name terminator.
        push_byte(8'd9);
        push_byte(8'd10);
        push_byte(8'd11);
        push_byte(8'd12);
        push_byte(8'd13);
        push_byte(8'd32);
        push_byte(CH_OPEN);
        push_byte("0");
        push_byte("z");
        push_byte("_");
        push_byte("+");
        push_byte("#");
        push_byte("=");
        push_byte(":");
        push_byte("-");
        push_byte(CH_QUOTE);
        push_byte(CH_QUOTE);
        push_byte(CH_BSLASH);
        push_byte(CH_BSLASH);
        push_byte(CH_BSLASH);
        push_byte(CH_QUOTE);
        push_byte(8'd127);
        push_byte(8'd32);
        push_byte(CH_QUOTE);
        push_byte(CH_CLOSE);

        // A pair at both length limits, then random pairs.
        push_head(NAME_MAX);
        push_body(VALUE_MAX);
        push_tail();
        pairs = 0;
        while (pushed_count < RANDOM_BYTES) begin
            if (pairs == 8) hold_next = 1'b1;
            push_head(($urandom_range(15) == 0) ? $urandom_range(NAME_MAX, 1)
                                                : $urandom_range(8, 1));
            push_body($urandom_range(12));
            push_tail();
            pairs++;
        end

        // Let everything settle, then end the stream in one of the halting ways.
        hold_next = 1'b1;
        path = halt_path_e'($urandom_range(END_VALUE_LONG, END_STOP));
        case (path)
            END_STOP: begin
                do b = 8'($urandom_range(255)); while (byte_is_blank(b) || b == CH_OPEN);
                push_byte(b);
            end
            END_NAME_START: begin
                push_blanks();
                push_byte(CH_OPEN);
                push_blanks();
                do b = 8'($urandom_range(255)); while (byte_is_blank(b) || byte_is_alnum(b));
                push_byte(b);
            end
            END_NO_QUOTE: begin
                push_head($urandom_range(6, 1));
                push_term();
                push_blanks();
                do b = 8'($urandom_range(255)); while (byte_is_blank(b) || b == CH_QUOTE);
                push_byte(b);
            end
            END_BAD_ESCAPE: begin
                push_head($urandom_range(6, 1));
                push_body($urandom_range(6));
                push_byte(CH_BSLASH);
                do b = 8'($urandom_range(255)); while (b == CH_BSLASH || b == CH_QUOTE);
                push_byte(b);
            end
            END_BAD_VALUE_BYTE: begin
                push_head($urandom_range(6, 1));
                push_body($urandom_range(6));
                push_byte($urandom_range(1) ? 8'($urandom_range(31)) :
                                              8'($urandom_range(255, 128)));
            end
            END_NO_CLOSE: begin
                push_head($urandom_range(6, 1));
                push_body($urandom_range(6));
                push_byte(CH_QUOTE);
                push_blanks();
                do b = 8'($urandom_range(255)); while (byte_is_blank(b) || b == CH_CLOSE);
                push_byte(b);
            end
            END_EOF: begin
                // Cut the stream off at a random point of a pair.
                cut = parse_phase_e'($urandom_range(SEEK_CLOSE, SEEK_OPEN));
                case (cut)
                    SEEK_OPEN: push_blanks();
                    NAME_HEAD: begin
                        push_blanks();
                        push_byte(CH_OPEN);
                    end
                    NAME_BODY: push_head($urandom_range(6, 1));
                    SEEK_QUOTE: begin
                        push_head($urandom_range(6, 1));
                        push_term();
                    end
                    IN_VALUE: begin
                        push_head($urandom_range(6, 1));
                        push_body($urandom_range(6));
                        if ($urandom_range(1)) push_byte(CH_BSLASH);
                    end
                    default: begin
                        push_head($urandom_range(6, 1));
                        push_body($urandom_range(6));
                        push_byte(CH_QUOTE);
                    end
                endcase
                push_byte(8'($urandom_range(255)), 1'b1);
            end
            END_NAME_LONG: push_head(NAME_MAX + 1);
            default: begin
                push_head($urandom_range(4, 1));
                push_body(VALUE_MAX + 1);
            end
        endcase

        // A halted parser must keep reporting the same status.
        repeat (20) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (parse_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
